/* hw/rtl/bmd3_pkg.sv */
// bmd3_pkg: constants, types and helpers for the 3D binary mask dilation core.
// Self-contained; used by binary_mask_dilate_3d_core.

package bmd3_pkg;

    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 64;

    localparam int DIM_W   = 7;
    localparam int IDX_W   = 2;
    localparam int DIM_RST = 64;

    localparam int X_W     = $clog2(MAX_X);
    localparam int Y_W     = $clog2(MAX_Y);
    localparam int Z_W     = $clog2(MAX_Z);
    localparam int ZC_W    = $clog2(MAX_Z + 2);
    localparam int COL_AW  = X_W + Y_W;
    localparam int COL_DEP = 1 << COL_AW;

    localparam logic [IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DIM_Z = 2'd2;

    // row buffer entry: raw bit, z-dilated bit, raw bit one row up
    typedef struct packed {
        logic r;
        logic z;
        logic u;
    } t_row;

    // column stage
    typedef struct packed {
        logic              vnew;
        logic              zlo;
        logic              sv;
        logic              emit;
        logic              last;
        logic              xlo;
        logic              xhi;
        logic              ylo;
        logic              yhi;
        logic [COL_AW-1:0] maddr;
    } t_s1;

    // row stage
    typedef struct packed {
        logic           raw;
        logic           zd;
        logic           sv;
        logic           emit;
        logic           last;
        logic           xlo;
        logic           xhi;
        logic           ylo;
        logic           yhi;
        logic [X_W-1:0] px;
    } t_s2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/binary_mask_dilate_3d_core.sv */
// binary_mask_dilate_3d_core: streaming 6-connected dilation of a 3D bit mask.
// Column memory (two past planes per x,y) plus a row memory; uses bmd3_pkg.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------
//   in      | i_in_valid / o_in_stall   | i_func, i_voxel_bit
//   out     | o_out_valid / i_out_stall | o_dilated_bit, o_last_voxel
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_stall is low; a taken request moves through the
// column memory read, the row memory read and the output register, in that order.
// Sync active-low reset: dims to 64, stream position to zero. Memories are not
// cleared; only entries written in the current volume are ever used.
// Output register plus one skid entry; o_in_stall is the skid-full flag.

module binary_mask_dilate_3d_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic                          i_voxel_bit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_dilated_bit,
    output logic                          o_last_voxel,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bmd3_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bmd3_pkg::DIM_W-1:0]    i_cfg_data
);

    localparam int X_W    = bmd3_pkg::X_W;
    localparam int Y_W    = bmd3_pkg::Y_W;
    localparam int Z_W    = bmd3_pkg::Z_W;
    localparam int ZC_W   = bmd3_pkg::ZC_W;
    localparam int DIM_W  = bmd3_pkg::DIM_W;
    localparam int COL_AW = bmd3_pkg::COL_AW;

    logic [DIM_W-1:0] r_fx, r_fy, r_fz;
    logic [X_W-1:0]   r_ix, n_ix, r_ox, n_ox;
    logic [Y_W-1:0]   r_iy, n_iy, r_oy, n_oy;
    logic [ZC_W-1:0]  r_iz, n_iz;
    logic [Z_W-1:0]   r_oz, n_oz;

    logic [DIM_W-1:0] fx_m1, fy_m1, fz_m1;
    logic [X_W-1:0]   x_end;
    logic [Y_W-1:0]   y_end;
    logic [Z_W-1:0]   z_end;

    logic en, acc, cfg_hit;
    logic iz_ge1, iz_ge2, in_vol, emit, last, vnew;

    logic                 r_s1_valid, r_s2_valid;
    bmd3_pkg::t_s1        r_s1, n_s1;
    bmd3_pkg::t_s2        r_s2, n_s2;

    logic [1:0]           r_col_mem [bmd3_pkg::COL_DEP];
    logic [1:0]           r_col_rd;
    logic [1:0]           col_wdata;
    logic [COL_AW-1:0]    col_raddr;

    bmd3_pkg::t_row       r_row_mem [bmd3_pkg::MAX_X];
    bmd3_pkg::t_row       r_row_rd, r_hq, row_wdata;
    logic [X_W-1:0]       row_raddr;
    logic                 row_byp;
    logic                 r_rq1;

    logic push, push_bit, out_take;
    logic r_out_valid, r_out_bit, r_out_last;
    logic r_sk_valid, r_sk_bit, r_sk_last;

    // ---------------- control and counters ----------------
    assign o_cfg_ready = 1'b1;
    assign en          = !r_sk_valid;
    assign o_in_stall  = r_sk_valid;
    assign acc         = i_in_valid && en;

    assign fx_m1 = r_fx - 1'b1;
    assign fy_m1 = r_fy - 1'b1;
    assign fz_m1 = r_fz - 1'b1;
    assign x_end = X_W'(fx_m1);
    assign y_end = Y_W'(fy_m1);
    assign z_end = Z_W'(fz_m1);

    always_comb begin
        unique case (i_cfg_index)
            bmd3_pkg::CFG_DIM_X,
            bmd3_pkg::CFG_DIM_Y,
            bmd3_pkg::CFG_DIM_Z: cfg_hit = i_cfg_valid;
            default:             cfg_hit = 1'b0;
        endcase
    end

    assign iz_ge1 = (r_iz != '0);
    assign iz_ge2 = (r_iz > ZC_W'(1));
    assign in_vol = (r_iz < ZC_W'(r_fz));
    assign emit   = iz_ge2 || (iz_ge1 && (r_iy != '0));
    assign last   = emit && (r_ox == x_end) && (r_oy == y_end) && (r_oz == z_end);
    assign vnew   = !i_func && i_voxel_bit && in_vol;

    always_comb begin
        n_ix = r_ix;
        n_iy = r_iy;
        n_iz = r_iz;
        n_ox = r_ox;
        n_oy = r_oy;
        n_oz = r_oz;
        priority if (cfg_hit || (acc && last)) begin
            n_ix = '0;
            n_iy = '0;
            n_iz = '0;
            n_ox = '0;
            n_oy = '0;
            n_oz = '0;
        end else if (acc) begin
            if (r_ix == x_end) begin
                n_ix = '0;
                if (r_iy == y_end) begin
                    n_iy = '0;
                    n_iz = r_iz + 1'b1;
                end else begin
                    n_iy = r_iy + 1'b1;
                end
            end else begin
                n_ix = r_ix + 1'b1;
            end
            if (emit) begin
                if (r_ox == x_end) begin
                    n_ox = '0;
                    if (r_oy == y_end) begin
                        n_oy = '0;
                        n_oz = r_oz + 1'b1;
                    end else begin
                        n_oy = r_oy + 1'b1;
                    end
                end else begin
                    n_ox = r_ox + 1'b1;
                end
            end
        end else begin
            n_ix = r_ix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= bmd3_pkg::clamp_dim(DIM_W'(bmd3_pkg::DIM_RST), bmd3_pkg::MAX_X);
            r_fy <= bmd3_pkg::clamp_dim(DIM_W'(bmd3_pkg::DIM_RST), bmd3_pkg::MAX_Y);
            r_fz <= bmd3_pkg::clamp_dim(DIM_W'(bmd3_pkg::DIM_RST), bmd3_pkg::MAX_Z);
            r_ix <= '0;
            r_iy <= '0;
            r_iz <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_oz <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bmd3_pkg::CFG_DIM_X: r_fx <= bmd3_pkg::clamp_dim(i_cfg_data, bmd3_pkg::MAX_X);
                    bmd3_pkg::CFG_DIM_Y: r_fy <= bmd3_pkg::clamp_dim(i_cfg_data, bmd3_pkg::MAX_Y);
                    bmd3_pkg::CFG_DIM_Z: r_fz <= bmd3_pkg::clamp_dim(i_cfg_data, bmd3_pkg::MAX_Z);
                    default: ;
                endcase
            end
            r_ix <= n_ix;
            r_iy <= n_iy;
            r_iz <= n_iz;
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_oz <= n_oz;
        end
    end

    // ---------------- stage 1: column memory (two planes back) ----------------
    assign col_raddr = {r_iy, r_ix};
    assign col_wdata = {r_s1.vnew, r_col_rd[1]};

    always_comb begin
        n_s1.vnew  = vnew;
        n_s1.zlo   = iz_ge2;
        n_s1.sv    = iz_ge1;
        n_s1.emit  = emit;
        n_s1.last  = last;
        n_s1.xlo   = (r_ox != '0);
        n_s1.xhi   = (r_ox != x_end);
        n_s1.ylo   = (r_oy != '0);
        n_s1.yhi   = (r_oy != y_end);
        n_s1.maddr = col_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s1_valid) begin
                r_col_mem[r_s1.maddr] <= col_wdata;
            end
            if (acc) begin
                r_col_rd <= (r_s1_valid && (r_s1.maddr == col_raddr)) ?
                            col_wdata : r_col_mem[col_raddr];
            end
        end
    end

    // ---------------- stage 2: row memory ----------------
    always_comb begin
        n_s2.raw  = r_col_rd[1];
        n_s2.zd   = r_col_rd[1] | (r_s1.zlo & r_col_rd[0]) | r_s1.vnew;
        n_s2.sv   = r_s1.sv;
        n_s2.emit = r_s1.emit;
        n_s2.last = r_s1.last;
        n_s2.xlo  = r_s1.xlo;
        n_s2.xhi  = r_s1.xhi;
        n_s2.ylo  = r_s1.ylo;
        n_s2.yhi  = r_s1.yhi;
        n_s2.px   = r_s1.maddr[X_W-1:0];
    end

    // read one voxel ahead: the entry for the next output position
    assign row_raddr = (n_s2.px == x_end) ? '0 : n_s2.px + 1'b1;
    assign row_wdata = '{r: r_s2.raw, z: r_s2.zd, u: r_hq.r};
    assign row_byp   = r_s2_valid && r_s2.sv && (row_raddr == r_s2.px);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s2_valid && r_s2.sv) begin
                r_row_mem[r_s2.px] <= row_wdata;
            end
            if (r_s1_valid && r_s1.sv) begin
                r_row_rd <= row_byp ? row_wdata : r_row_mem[row_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid && r_s2.sv) begin
            r_hq  <= (r_fx == DIM_W'(1)) ? row_wdata : r_row_rd;
            r_rq1 <= r_hq.r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    // ---------------- output register and skid ----------------
    assign push     = en && r_s2_valid && r_s2.emit;
    assign push_bit = r_hq.z | (r_s2.xlo & r_rq1) | (r_s2.xhi & r_row_rd.r)
                    | (r_s2.ylo & r_hq.u) | (r_s2.yhi & r_s2.raw);
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            priority if (r_sk_valid) begin
                if (out_take) begin
                    r_out_valid <= 1'b1;
                    r_sk_valid  <= 1'b0;
                end
            end else if (push) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_sk_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_sk_valid) begin
            if (out_take) begin
                r_out_bit  <= r_sk_bit;
                r_out_last <= r_sk_last;
            end
        end else if (push) begin
            if (!r_out_valid || out_take) begin
                r_out_bit  <= push_bit;
                r_out_last <= r_s2.last;
            end else begin
                r_sk_bit  <= push_bit;
                r_sk_last <= r_s2.last;
            end
        end else begin
            r_out_bit <= r_out_bit;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_dilated_bit = r_out_bit;
    assign o_last_voxel  = r_out_last;

    // ---------------- assertions ----------------
    a_skid_under_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_valid && i_out_stall) |=> r_sk_valid)
        else $error("result pushed into a stalled output was lost");

    a_in_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ix <= x_end) && (r_iy <= y_end))
        else $error("input position outside the plane");

    a_out_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oz <= z_end) && (r_iz <= ZC_W'(r_fz + 1)))
        else $error("stream position beyond volume plus drain");

endmodule
